FILE: hw/rtl/ccg_pkg.sv
// Shared widths, payload types and stage structs for the circle contact pipeline.
// No dependencies; every module of the block imports this package (ccg_stream_if does not).
package ccg_pkg;

  localparam int CW        = 24;           // coordinate width, signed
  localparam int RW        = 23;           // radius width, unsigned
  localparam int NW        = 16;           // normal width, Q1.14
  localparam int NORM_BITS = 14;
  localparam int QW        = NORM_BITS + 1; // quotient bits, |n| <= 2**NORM_BITS
  localparam int SQW       = 2 * CW;       // one squared component
  localparam int D2W       = SQW + 1;      // squared distance
  localparam int RAD_W     = D2W + 1;      // radicand padded to an even width
  localparam int ROOT_W    = RAD_W / 2;    // distance
  localparam int REM_W     = ROOT_W + 3;   // root remainder with shifted-in pair
  localparam int NUM_W     = CW + QW + 2;  // divider dividend / remainder
  localparam int PROD_W    = RW + QW;      // radius times normal magnitude

  localparam logic signed [NW-1:0] NORM_ONE = NW'(2 ** NORM_BITS);

  typedef struct packed {
    logic signed [CW-1:0] center_a_x;
    logic signed [CW-1:0] center_a_y;
    logic signed [CW-1:0] center_b_x;
    logic signed [CW-1:0] center_b_y;
    logic [RW-1:0]        radius_a;
    logic [RW-1:0]        radius_b;
    logic                 a_is_circle;
    logic                 b_is_circle;
  } pair_t;

  typedef struct packed {
    logic                 hit;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic [CW-1:0]        gap;
    logic signed [CW-1:0] touch_a_x;
    logic signed [CW-1:0] touch_a_y;
    logic signed [CW-1:0] touch_b_x;
    logic signed [CW-1:0] touch_b_y;
  } contact_t;

  // Values that ride along the pipeline with each pair.
  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic [RW-1:0]        ra;
    logic [RW-1:0]        rb;
    logic                 sx;     // dx negative
    logic                 sy;     // dy negative
    logic [CW-1:0]        mx;     // |dx|
    logic [CW-1:0]        my;     // |dy|
    logic [CW-1:0]        rsum;
    logic                 hit;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [D2W-1:0] dist2;
  } front_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] dlen;
  } root_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] dlen;
    logic [QW-1:0]     qx;
    logic [QW-1:0]     qy;
  } quot_t;

endpackage

FILE: hw/rtl/ccg_stream_if.sv
// Valid/ready stream channel carrying one payload word per handshake.
// Payload type is a parameter; the block uses ccg_pkg::pair_t and ccg_pkg::contact_t.
interface ccg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/circle_contact_generation_unit.sv
// Circle pair contact generator, fully pipelined.
// Depth: 46 register stages from the input to the output register.
// Throughput: one pair per cycle; the square root (one bit per stage) and the
// normal divider (one bit per stage) set the depth. A stalled output holds the whole pipe.
// Reset: rst_ni clears every stage valid bit asynchronously; payload registers are not reset.
module circle_contact_generation_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  ccg_stream_if.sink   pair_i,
  ccg_stream_if.source contact_o
);
  import ccg_pkg::*;

  logic     en;
  logic     front_vld, root_vld, quot_vld;
  front_t   front_w;
  root_t    root_w;
  quot_t    quot_w;
  pair_t    pair_w;
  contact_t contact_w;

  // advance every stage unless the output word is held
  assign en           = !contact_o.valid || contact_o.ready;
  assign pair_i.ready = en;
  assign pair_w       = pair_i.data;

  ccg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (pair_i.valid),
    .pair_i  (pair_w),
    .vld_o   (front_vld),
    .front_o (front_w)
  );

  ccg_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (front_vld),
    .front_i (front_w),
    .vld_o   (root_vld),
    .root_o  (root_w)
  );

  ccg_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (root_vld),
    .root_i (root_w),
    .vld_o  (quot_vld),
    .quot_o (quot_w)
  );

  ccg_touch u_touch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (quot_vld),
    .quot_i    (quot_w),
    .vld_o     (contact_o.valid),
    .contact_o (contact_w)
  );

  assign contact_o.data = contact_w;

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (contact_o.valid && !contact_o.data.hit) |->
      (contact_o.data.normal_x == '0 && contact_o.data.normal_y == '0 &&
       contact_o.data.gap == '0 && contact_o.data.touch_a_x == '0 &&
       contact_o.data.touch_b_y == '0))
    else $error("miss word carries nonzero fields");

  a_normal_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (contact_o.valid && contact_o.data.hit) |->
      (contact_o.data.normal_x <= NORM_ONE && contact_o.data.normal_x >= -NORM_ONE &&
       contact_o.data.normal_y <= NORM_ONE && contact_o.data.normal_y >= -NORM_ONE))
    else $error("normal component exceeds unit length");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (contact_o.valid && !contact_o.ready) |-> !pair_i.ready)
    else $error("input taken while output word is held");

  a_held_word_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (contact_o.valid && !contact_o.ready) |=> (contact_o.valid && $stable(contact_w)))
    else $error("held output word changed");

endmodule

FILE: hw/rtl/ccg_front.sv
// Front end: centre differences, squares and the overlap test, three register stages.
// Depends on ccg_pkg.
module ccg_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  ccg_pkg::pair_t pair_i,
  output logic           vld_o,
  output ccg_pkg::front_t front_o
);
  import ccg_pkg::*;

  logic signed [CW:0] dx_d, dy_d, ndx_d, ndy_d;
  side_t              s1_d;
  logic               s1_vld_q, s2_vld_q, s3_vld_q;
  side_t              s1_q, s2_q;
  side_t              s3_side_d;
  logic [SQW-1:0]     sqx_q, sqy_q, rs2_q;
  logic [D2W-1:0]     dist2_d;
  front_t             s3_q;

  assign dx_d  = {pair_i.center_b_x[CW-1], pair_i.center_b_x}
               - {pair_i.center_a_x[CW-1], pair_i.center_a_x};
  assign dy_d  = {pair_i.center_b_y[CW-1], pair_i.center_b_y}
               - {pair_i.center_a_y[CW-1], pair_i.center_a_y};
  assign ndx_d = -dx_d;
  assign ndy_d = -dy_d;

  always_comb begin
    s1_d.ax   = pair_i.center_a_x;
    s1_d.ay   = pair_i.center_a_y;
    s1_d.bx   = pair_i.center_b_x;
    s1_d.by   = pair_i.center_b_y;
    s1_d.ra   = pair_i.radius_a;
    s1_d.rb   = pair_i.radius_b;
    s1_d.sx   = dx_d[CW];
    s1_d.sy   = dy_d[CW];
    // magnitude of a 25-bit difference of two 24-bit values fits 24 bits
    s1_d.mx   = dx_d[CW] ? ndx_d[CW-1:0] : dx_d[CW-1:0];
    s1_d.my   = dy_d[CW] ? ndy_d[CW-1:0] : dy_d[CW-1:0];
    s1_d.rsum = {1'b0, pair_i.radius_a} + {1'b0, pair_i.radius_b};
    s1_d.hit  = pair_i.a_is_circle & pair_i.b_is_circle;
  end

  assign dist2_d = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    s3_side_d     = s2_q;
    s3_side_d.hit = s2_q.hit && (dist2_d <= {1'b0, rs2_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      s2_q  <= s1_q;
      sqx_q <= s1_q.mx * s1_q.mx;
      sqy_q <= s1_q.my * s1_q.my;
      rs2_q <= s1_q.rsum * s1_q.rsum;
      s3_q.side       <= s3_side_d;
      s3_q.dist2      <= dist2_d;
    end
  end

  assign vld_o   = s3_vld_q;
  assign front_o = s3_q;

endmodule

FILE: hw/rtl/ccg_sqrt_pipe.sv
// Integer square root of the squared distance, one root bit per register stage.
// Depends on ccg_pkg.
module ccg_sqrt_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  ccg_pkg::front_t front_i,
  output logic            vld_o,
  output ccg_pkg::root_t  root_o
);
  import ccg_pkg::*;

  logic [ROOT_W-1:0] vld_q;
  side_t             side_q [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_in;
    side_t             side_in;
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign side_in = front_i.side;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {1'b0, front_i.dist2};
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down the next radicand pair and try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o       = vld_q[ROOT_W-1];
  assign root_o.side = side_q[ROOT_W-1];
  assign root_o.dlen = root_q[ROOT_W-1];

endmodule

FILE: hw/rtl/ccg_div_pipe.sv
// Rounded normal magnitudes |d|*2^14/dist for both axes: a dividend stage, then
// one quotient bit per register stage in two lanes. Depends on ccg_pkg.
module ccg_div_pipe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  ccg_pkg::root_t root_i,
  output logic           vld_o,
  output ccg_pkg::quot_t quot_o
);
  import ccg_pkg::*;

  logic              pre_vld_q;
  side_t             pre_side_q;
  logic [ROOT_W-1:0] pre_dist_q;
  logic [NUM_W-1:0]  pre_num_q [2];

  logic [QW-1:0]     vld_q;
  side_t             side_q [QW];
  logic [ROOT_W-1:0] dist_q [QW];
  logic [NUM_W-1:0]  rem_q  [QW][2];
  logic [QW-1:0]     quo_q  [QW][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (en_i) begin
      pre_vld_q <= vld_i;
    end
  end

  // dividend is |d|*2^15 + dist, divisor 2*dist: round to nearest
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_side_q   <= root_i.side;
      pre_dist_q   <= root_i.dlen;
      pre_num_q[0] <= NUM_W'({root_i.side.mx, QW'(0)}) + NUM_W'(root_i.dlen);
      pre_num_q[1] <= NUM_W'({root_i.side.my, QW'(0)}) + NUM_W'(root_i.dlen);
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;
    logic              vld_in;
    side_t             side_in;
    logic [ROOT_W-1:0] dist_in;
    logic [NUM_W-1:0]  dsh;

    if (j == 0) begin : g_first
      assign vld_in  = pre_vld_q;
      assign side_in = pre_side_q;
      assign dist_in = pre_dist_q;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign side_in = side_q[j-1];
      assign dist_in = dist_q[j-1];
    end

    assign dsh = NUM_W'({dist_in, 1'b0}) << SH;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= side_in;
        dist_q[j] <= dist_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NUM_W-1:0] rem_in;
      logic [QW-1:0]    quo_in;

      if (j == 0) begin : g_first
        assign rem_in = pre_num_q[l];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[j-1][l];
        assign quo_in = quo_q[j-1][l];
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (rem_in >= dsh) begin
            rem_q[j][l] <= rem_in - dsh;
            quo_q[j][l] <= {quo_in[QW-2:0], 1'b1};
          end else begin
            rem_q[j][l] <= rem_in;
            quo_q[j][l] <= {quo_in[QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // coincident centres: zero divisor, force a zero normal
  assign vld_o       = vld_q[QW-1];
  assign quot_o.side = side_q[QW-1];
  assign quot_o.dlen = dist_q[QW-1];
  assign quot_o.qx   = (dist_q[QW-1] == '0) ? '0 : quo_q[QW-1][0];
  assign quot_o.qy   = (dist_q[QW-1] == '0) ? '0 : quo_q[QW-1][1];

endmodule

FILE: hw/rtl/ccg_touch.sv
// Contact points and gap: radius-by-normal products, then rounding, offset,
// saturation and the output register. Depends on ccg_pkg.
module ccg_touch (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  ccg_pkg::quot_t    quot_i,
  output logic              vld_o,
  output ccg_pkg::contact_t contact_o
);
  import ccg_pkg::*;

  function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] c,
                                                 input logic [PROD_W-1:0]  p,
                                                 input logic               neg);
    logic [PROD_W:0]      r;
    logic signed [CW+1:0] m;
    logic signed [CW+1:0] s;
    r = {1'b0, p} + ((PROD_W + 1)'(1) << (NORM_BITS - 1));
    m = (CW + 2)'(r >> NORM_BITS);
    s = neg ? ({{2{c[CW-1]}}, c} - m) : ({{2{c[CW-1]}}, c} + m);
    // clamp when the top three bits disagree
    if ((s[CW+1:CW-1] == 3'b000) || (s[CW+1:CW-1] == 3'b111)) begin
      return s[CW-1:0];
    end else begin
      return s[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  logic                 p_vld_q, o_vld_q;
  side_t                p_side_q;
  logic [PROD_W-1:0]    pax_q, pay_q, pbx_q, pby_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic [CW-1:0]        gap_q;
  logic [CW:0]          gap_d;
  logic signed [NW-1:0] qx_d, qy_d;
  contact_t             out_d, out_q;

  assign gap_d = {1'b0, quot_i.side.rsum} - quot_i.dlen;
  assign qx_d  = NW'(quot_i.qx);
  assign qy_d  = NW'(quot_i.qy);

  always_comb begin
    out_d = '0;
    if (p_side_q.hit) begin
      out_d.hit       = 1'b1;
      out_d.normal_x  = nx_q;
      out_d.normal_y  = ny_q;
      out_d.gap       = gap_q;
      out_d.touch_a_x = place(p_side_q.ax, pax_q, p_side_q.sx);
      out_d.touch_a_y = place(p_side_q.ay, pay_q, p_side_q.sy);
      out_d.touch_b_x = place(p_side_q.bx, pbx_q, !p_side_q.sx);
      out_d.touch_b_y = place(p_side_q.by, pby_q, !p_side_q.sy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= vld_i;
      o_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_side_q <= quot_i.side;
      pax_q    <= quot_i.side.ra * quot_i.qx;
      pay_q    <= quot_i.side.ra * quot_i.qy;
      pbx_q    <= quot_i.side.rb * quot_i.qx;
      pby_q    <= quot_i.side.rb * quot_i.qy;
      nx_q     <= quot_i.side.sx ? -qx_d : qx_d;
      ny_q     <= quot_i.side.sy ? -qy_d : qy_d;
      // dist never exceeds rsum on a hit
      gap_q    <= gap_d[CW-1:0];
      out_q    <= out_d;
    end
  end

  assign vld_o     = o_vld_q;
  assign contact_o = out_q;

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for circle_contact_generation_unit: random and directed circle pairs.
// Depends on ccg_pkg, ccg_stream_if and the unit from the RTL; predicts each contact word in-bench.
`timescale 1ns / 1ps

module tb_top;
  import ccg_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ccg_stream_if #(.payload_t(pair_t))    pair_if ();
  ccg_stream_if #(.payload_t(contact_t)) contact_if ();

  circle_contact_generation_unit DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pair_i    (pair_if.sink),
    .contact_o (contact_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  int       mismatch_count = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  int       hold_off = 0;
  bit       hold_done = 1'b0;
  bit       feed_done = 1'b0;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint floor_sqrt(longint x);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint unit_part(longint d, longint dlen);
    longint q;
    if (dlen == 0) return 0;
    q = ((mag(d) << (NORM_BITS + 1)) + dlen) / (dlen << 1);
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint radius_times(longint r, longint n);
    longint m;
    m = (r * mag(n) + (64'sd1 << (NORM_BITS - 1))) >>> NORM_BITS;
    return (n < 0) ? -m : m;
  endfunction

  function automatic logic [CW-1:0] clamp24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[CW-1:0];
  endfunction

  function automatic contact_t contact_of(pair_t p);
    contact_t c;
    longint ax, ay, bx, by, ra, rb, dx, dy, d2, rs, dlen, nx, ny, g;
    c = '0;
    ax = p.center_a_x; ay = p.center_a_y;
    bx = p.center_b_x; by = p.center_b_y;
    ra = p.radius_a;   rb = p.radius_b;
    dx = bx - ax; dy = by - ay;
    d2 = dx * dx + dy * dy;
    rs = ra + rb;
    if (!(p.a_is_circle && p.b_is_circle) || d2 > rs * rs) return c;
    dlen = floor_sqrt(d2);
    nx = unit_part(dx, dlen);
    ny = unit_part(dy, dlen);
    g = mag(rs - dlen);
    if (g > 16777215) g = 16777215;
    c.hit       = 1'b1;
    c.normal_x  = nx[NW-1:0];
    c.normal_y  = ny[NW-1:0];
    c.gap       = g[CW-1:0];
    c.touch_a_x = clamp24(ax + radius_times(ra, nx));
    c.touch_a_y = clamp24(ay + radius_times(ra, ny));
    c.touch_b_x = clamp24(bx - radius_times(rb, nx));
    c.touch_b_y = clamp24(by - radius_times(rb, ny));
    return c;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return CW'($urandom);
      1:       return CW'($signed($urandom_range(0, 8000)) - 4000);
      2:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return CW'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  // Most random pairs place B near A (within 64 or 300000 on each axis) so that many of them touch.
  function automatic pair_t rand_pair();
    pair_t p;
    int    spread;
    p.center_a_x  = rand_coord();
    p.center_a_y  = rand_coord();
    p.radius_a    = $urandom_range(0, 3) == 0 ? RW'($urandom) : RW'($urandom_range(0, 300000));
    p.radius_b    = $urandom_range(0, 3) == 0 ? RW'($urandom) : RW'($urandom_range(0, 300000));
    p.a_is_circle = $urandom_range(0, 9) != 0;
    p.b_is_circle = $urandom_range(0, 9) != 0;
    if ($urandom_range(0, 3) != 0) begin
      spread = $urandom_range(0, 1) ? 64 : 300000;
      p.center_b_x = p.center_a_x + CW'($signed($urandom_range(0, 2 * spread)) - spread);
      p.center_b_y = p.center_a_y + CW'($signed($urandom_range(0, 2 * spread)) - spread);
    end else begin
      p.center_b_x = rand_coord();
      p.center_b_y = rand_coord();
    end
    return p;
  endfunction

  function automatic pair_t make_pair(int ax, int ay, int bx, int by, int ra, int rb,
                                      bit fa, bit fb);
    pair_t p;
    p.center_a_x = CW'(ax); p.center_a_y = CW'(ay);
    p.center_b_x = CW'(bx); p.center_b_y = CW'(by);
    p.radius_a = RW'(ra); p.radius_b = RW'(rb);
    p.a_is_circle = fa; p.b_is_circle = fb;
    return p;
  endfunction

  initial begin
    pair_t p;
    pending_pairs.push_back(make_pair(0, 0, 4096, 0, 4096, 4096, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 50, 50, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 3, 4, 1, 1, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 3, 4, 2, 3, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 1, 1));
    pending_pairs.push_back(make_pair(500, -700, 500, -700, 1234, 99, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 20, 20, 0, 1));
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 20, 20, 1, 0));
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 20, 20, 0, 0));
    pending_pairs.push_back(make_pair(8388607, 8388607, -8388608, -8388608,
                                      8388607, 8388607, 1, 1));
    pending_pairs.push_back(make_pair(-8388608, -8388608, 8388607, 8388607,
                                      8388607, 8388607, 1, 1));
    pending_pairs.push_back(make_pair(8388607, 0, 8388000, 0, 8388607, 8388607, 1, 1));
    pending_pairs.push_back(make_pair(-8388608, 0, -8388000, 0, 8388607, 8388607, 1, 1));
    pending_pairs.push_back(make_pair(0, -8388608, 0, 8388607, 8388607, 1, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, -5, 0, 5, 0, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, -7, 3, 3, 1, 1));
    pending_pairs.push_back(make_pair(1, 1, 2, 2, 8388607, 0, 1, 1));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, 8388607, 8388607, 1, 1));
    repeat (650) begin
      p = rand_pair();
      pending_pairs.push_back(p);
    end
    feed_done = 1'b1;
  end

  // Driver: offer words at the falling edge, gap-free during an opening burst, then with random gaps.
  initial begin
    pair_if.valid = 1'b0;
    pair_if.data  = '0;
    contact_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pair_if.valid && pair_if.ready) void'(pending_pairs.pop_front());
      burst_left <= (burst_left > 0) ? burst_left - 1 : 0;
      if (pending_pairs.size() != 0 && (burst_left > 0 || $urandom_range(0, 99) >= 31)) begin
        pair_if.valid <= 1'b1;
        pair_if.data  <= pending_pairs[0];
      end else begin
        pair_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off once the pipe is busy; else ready during the opening burst, random stalls after it.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && expected_contacts.size() > 30) begin
        hold_off  <= 120;
        hold_done <= 1'b1;
        contact_if.ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        contact_if.ready <= 1'b0;
      end else begin
        contact_if.ready <= (burst_left > 0) || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // Monitor and scoreboard at the rising edge.
  always @(posedge clk_i) begin
    contact_t want;
    if (rst_ni) begin
      if ((pair_if.valid && pair_if.ready) || (contact_if.valid && contact_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (pair_if.valid && pair_if.ready) begin
        expected_contacts.push_back(contact_of(pair_if.data));
      end
      if (contact_if.valid && contact_if.ready) begin
        if (expected_contacts.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected contact word %h", contact_if.data);
        end else begin
          want = expected_contacts.pop_front();
          if (contact_if.data !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
              $display("contact mismatch: hit %b/%b n %0d,%0d/%0d,%0d gap %0d/%0d",
                want.hit, contact_if.data.hit, want.normal_x, want.normal_y,
                contact_if.data.normal_x, contact_if.data.normal_y,
                want.gap, contact_if.data.gap);
              $display("  ta %0d,%0d/%0d,%0d tb %0d,%0d/%0d,%0d",
                want.touch_a_x, want.touch_a_y,
                contact_if.data.touch_a_x, contact_if.data.touch_a_y,
                want.touch_b_x, want.touch_b_y,
                contact_if.data.touch_b_x, contact_if.data.touch_b_y);
            end
          end
        end
      end
    end
  end

  initial begin
    burst_left = 150;
    repeat (2) @(posedge clk_i);
    rst_ni = 1'b1;
    fork
      begin
        wait (feed_done && pending_pairs.size() == 0 && expected_contacts.size() == 0);
        repeat (60) @(posedge clk_i);
        if (mismatch_count == 0 && expected_contacts.size() == 0)
          $display("tb_top: clean");
        else
          $display("tb_top: errors");
      end
      begin
        wait (quiet_cycles >= 2000);
        $display("tb_top: errors");
      end
    join_any
    $finish;
  end

endmodule
